// ===== design/pgc_pkg.sv =====
`default_nettype none

package pgc_pkg;

    localparam int DEF_MAX_DIM      = 64;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int COORD_FRAC_BITS  = 8;
    // integer bits of a coordinate, so also the width of a row or cell index
    localparam int ROW_W            = 16 - COORD_FRAC_BITS;

    localparam logic [6:0] MAP_ROWS_RESET = 7'd32;
    localparam logic [6:0] MAP_COLS_RESET = 7'd32;

    localparam logic [7:0] REG_MAP_ROWS = 8'd0;
    localparam logic [7:0] REG_MAP_COLS = 8'd1;

    localparam logic OP_CELL   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
        logic               cell_occupied;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               last_vertex;
    } pgc_req_t;

    typedef struct packed {
        logic hit;
        logic status;
    } pgc_rsp_t;

endpackage

`default_nettype wire

// ===== design/polygon_grid_collision.sv =====
`default_nettype none

// Polygon collision test against a one-bit occupancy grid.
// Requests are accepted when start is high and busy is low. A request either
// writes one grid cell or adds one polygon vertex (Q8.8 tile units). A vertex
// marked last closes the polygon and runs the test; that request alone gives a
// result, shown on rsp for exactly one cycle with done high.
// Cell write: row read at the request, modified and written back while busy.
// Vertex that is not last: stored at the request, busy stays low.
// Last vertex: the first vertex is loaded, then each edge is fetched and
// oriented; an edge inside one row writes its span directly, while a sloped
// edge does one multiply, an add, an 8-step restoring divide and a span
// memory read-modify-write for every row that it spans. A final walk then
// checks each row of the grid memory against its span; the divider sets the pace.
// A polygon with too many vertices, or one reaching above row 0 or below the
// map, answers in the cycle right after the request.
// After reset the grid memory is cleared one row per cycle, with busy high;
// configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while the block is idle.
// Results cannot be held off by the receiver.

module polygon_grid_collision #(
    parameter int MAX_DIM      = pgc_pkg::DEF_MAX_DIM,
    parameter int MAX_VERTICES = pgc_pkg::DEF_MAX_VERTICES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pgc_pkg::pgc_req_t req,
    output logic                  done,
    output pgc_pkg::pgc_rsp_t     rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_index,
    input  wire logic [6:0]       cfg_data
);

    localparam int FB   = pgc_pkg::COORD_FRAC_BITS;
    localparam int QW   = pgc_pkg::ROW_W;
    localparam int AW   = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int KW   = (QW > 2) ? $clog2(QW) : 1;
    localparam int PW   = 34;
    localparam int SW   = 17 + FB + QW - 1;
    localparam int NW   = SW + 4;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CELL_WR  = 4'd2;
    localparam logic [3:0] S_LOAD0    = 4'd3;
    localparam logic [3:0] S_FIRST    = 4'd4;
    localparam logic [3:0] S_FETCH    = 4'd5;
    localparam logic [3:0] S_EDGE     = 4'd6;
    localparam logic [3:0] S_SETUP    = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_ADD      = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_PT       = 4'd11;
    localparam logic [3:0] S_SPAN_WR  = 4'd12;
    localparam logic [3:0] S_WALK_RD  = 4'd13;
    localparam logic [3:0] S_WALK_CHK = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0]             state_reg;
    logic [AW-1:0]          clr_reg;
    logic [AW-1:0]          crow_reg;
    logic [AW-1:0]          ccol_reg;
    logic                   cocc_reg;
    logic                   cell_ok_reg;
    logic [6:0]             map_rows_reg;
    logic [6:0]             map_cols_reg;
    logic [CNTW-1:0]        vcount_reg;
    logic [CNTW-1:0]        n_reg;
    logic                   ovf_reg;
    logic signed [15:0]     miny_reg;
    logic signed [15:0]     maxy_reg;
    logic [VW-1:0]          e_reg;
    logic [31:0]            first_reg;
    logic [31:0]            a_reg;
    logic signed [15:0]     tx_reg;
    logic signed [15:0]     ty_reg;
    logic signed [15:0]     bx_reg;
    logic signed [15:0]     by_reg;
    logic signed [16:0]     dx_reg;
    logic signed [16:0]     dy_reg;
    logic signed [16:0]     py_reg;
    logic signed [PW-1:0]   prod0_reg;
    logic signed [PW-1:0]   prod1_reg;
    logic [NW-1:0]          rem_reg;
    logic [SW-1:0]          dsh_reg;
    logic [QW-1:0]          q_reg;
    logic [KW-1:0]          k_reg;
    logic                   firstpt_reg;
    logic                   flat_reg;
    logic signed [QW-1:0]   prev_reg;
    logic signed [QW-1:0]   lo_reg;
    logic signed [QW-1:0]   hi_reg;
    logic signed [QW-1:0]   row_reg;
    logic signed [QW-1:0]   top_reg;
    logic signed [QW-1:0]   bot_reg;
    logic [MAX_DIM-1:0]     span_vld_reg;
    logic                   hit_reg;
    logic                   status_reg;

    // memories: grid one row per word, vertices, per-row spans
    logic [MAX_DIM-1:0]     grid_mem [MAX_DIM];
    logic [MAX_DIM-1:0]     grid_q;
    logic [31:0]            vtx_mem [MAX_VERTICES];
    logic [31:0]            vtx_q;
    logic [2*QW-1:0]        span_mem [MAX_DIM];
    logic [2*QW-1:0]        span_q;

    logic                   acc;
    logic                   vfull;
    logic                   ovf_now;
    logic                   in_range;
    logic signed [15:0]     vy_c;
    logic signed [15:0]     miny_n;
    logic signed [15:0]     maxy_n;
    logic signed [QW-1:0]   top_n;
    logic signed [QW-1:0]   bot_n;
    logic [8:0]             rows_used;
    logic [8:0]             cols_used;
    logic                   early_hit;
    logic [8:0]             crow_ext;
    logic [8:0]             ccol_ext;
    logic [AW-1:0]          row_idx;
    logic                   last_edge;
    logic [31:0]            b_vtx;
    logic signed [15:0]     b_y;
    logic signed [15:0]     a_y;
    logic signed [QW-1:0]   lt_c;
    logic signed [QW-1:0]   lb_c;
    logic signed [16:0]     dy_c;
    logic signed [15:0]     mnx_c;
    logic signed [15:0]     mxx_c;
    logic [NW-1:0]          rem_init;
    logic [SW-1:0]          dsh_init;
    logic                   div_ge;
    logic signed [QW-1:0]   cell_c;
    logic signed [QW-1:0]   sl_c;
    logic signed [QW-1:0]   sr_c;
    logic                   vld_c;
    logic signed [QW-1:0]   new_l;
    logic signed [QW-1:0]   new_r;
    logic [MAX_DIM-1:0]     mask_c;
    logic                   walk_hit;
    logic                   grid_we;
    logic [AW-1:0]          grid_waddr;
    logic [MAX_DIM-1:0]     grid_wdata;
    logic [AW-1:0]          grid_raddr;
    logic                   vtx_we;
    logic [VW-1:0]          vtx_raddr;
    logic                   span_we;
    logic [AW-1:0]          span_raddr;

    assign acc       = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign rsp.hit   = hit_reg;
    assign rsp.status = status_reg;
    assign cfg_ready = 1'b1;

    assign vfull    = (int'(vcount_reg) >= MAX_VERTICES);
    assign ovf_now  = ovf_reg || vfull;
    assign in_range = (int'(req.cell_row) < MAX_DIM) && (int'(req.cell_col) < MAX_DIM);
    assign crow_ext = {3'b000, req.cell_row};
    assign ccol_ext = {3'b000, req.cell_col};
    assign vy_c     = req.vertex_y;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            miny_n = vy_c;
            maxy_n = vy_c;
        end
        else
        begin
            miny_n = (vy_c < miny_reg) ? vy_c : miny_reg;
            maxy_n = (vy_c > maxy_reg) ? vy_c : maxy_reg;
        end
    end

    // arithmetic shift of Q8.8 is the floor in tiles
    assign top_n = miny_n[15:FB];
    assign bot_n = maxy_n[15:FB];

    assign rows_used = (int'(map_rows_reg) > MAX_DIM) ? 9'(MAX_DIM) : {2'b00, map_rows_reg};
    assign cols_used = (int'(map_cols_reg) > MAX_DIM) ? 9'(MAX_DIM) : {2'b00, map_cols_reg};

    // the top and bottom rows always hold a vertex, so their spans are never empty
    assign early_hit = top_n[QW-1] || (int'(bot_n) >= int'(rows_used));

    assign row_idx   = row_reg[AW-1:0];
    assign last_edge = ((CNTW'(e_reg) + CNTW'(1)) == n_reg);
    assign b_vtx     = last_edge ? first_reg : vtx_q;
    assign a_y       = a_reg[15:0];
    assign b_y       = b_vtx[15:0];

    assign lt_c  = ty_reg[15:FB];
    assign lb_c  = by_reg[15:FB];
    assign dy_c  = {by_reg[15], by_reg} - {ty_reg[15], ty_reg};
    assign mnx_c = (tx_reg < bx_reg) ? tx_reg : bx_reg;
    assign mxx_c = (tx_reg < bx_reg) ? bx_reg : tx_reg;

    // bias by half the quotient range so the divide runs unsigned
    assign dsh_init = SW'({dy_reg, {(FB + QW - 1){1'b0}}});
    assign rem_init = NW'(prod0_reg) + NW'(prod1_reg) + NW'(dsh_init);
    assign div_ge   = (rem_reg >= NW'(dsh_reg));
    assign cell_c   = {~q_reg[QW-1], q_reg[QW-2:0]};

    assign sl_c  = span_q[2*QW-1:QW];
    assign sr_c  = span_q[QW-1:0];
    assign vld_c = span_vld_reg[row_idx];
    assign new_l = (!vld_c || (lo_reg < sl_c)) ? lo_reg : sl_c;
    assign new_r = (!vld_c || (hi_reg > sr_c)) ? hi_reg : sr_c;

    always_comb
    begin
        for (int c = 0; c < MAX_DIM; c++)
        begin
            mask_c[c] = (c >= int'(sl_c)) && (c <= int'(sr_c));
        end
    end

    assign walk_hit = vld_c && (sl_c[QW-1] || (int'(sr_c) >= int'(cols_used))
                      || (|(grid_q & mask_c)));

    always_comb
    begin
        grid_wdata = grid_q;
        grid_wdata[ccol_reg] = cocc_reg;
        if (state_reg == S_CLEAR)
        begin
            grid_wdata = '0;
        end
    end

    assign grid_we    = (state_reg == S_CLEAR) || ((state_reg == S_CELL_WR) && cell_ok_reg);
    assign grid_waddr = (state_reg == S_CLEAR) ? clr_reg : crow_reg;
    assign grid_raddr = (state_reg == S_IDLE) ? crow_ext[AW-1:0] : row_idx;
    assign vtx_we     = acc && (req.operation == pgc_pkg::OP_VERTEX) && !vfull;
    assign vtx_raddr  = (state_reg == S_LOAD0) ? '0 : (e_reg + VW'(1));
    assign span_we    = (state_reg == S_SPAN_WR);
    assign span_raddr = (state_reg == S_SETUP) ? lt_c[AW-1:0] : row_idx;

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_q <= grid_mem[grid_raddr];
        if (vtx_we)
        begin
            vtx_mem[vcount_reg[VW-1:0]] <= {req.vertex_x, req.vertex_y};
        end
        vtx_q <= vtx_mem[vtx_raddr];
        if (span_we)
        begin
            span_mem[row_idx] <= {new_l, new_r};
        end
        span_q <= span_mem[span_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_rows_reg <= pgc_pkg::MAP_ROWS_RESET;
            map_cols_reg <= pgc_pkg::MAP_COLS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pgc_pkg::REG_MAP_ROWS: map_rows_reg <= cfg_data;
                pgc_pkg::REG_MAP_COLS: map_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            crow_reg     <= '0;
            ccol_reg     <= '0;
            cocc_reg     <= 1'b0;
            cell_ok_reg  <= 1'b0;
            vcount_reg   <= '0;
            n_reg        <= '0;
            ovf_reg      <= 1'b0;
            miny_reg     <= '0;
            maxy_reg     <= '0;
            e_reg        <= '0;
            first_reg    <= '0;
            a_reg        <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            py_reg       <= '0;
            prod0_reg    <= '0;
            prod1_reg    <= '0;
            rem_reg      <= '0;
            dsh_reg      <= '0;
            q_reg        <= '0;
            k_reg        <= '0;
            firstpt_reg  <= 1'b0;
            flat_reg     <= 1'b0;
            prev_reg     <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            row_reg      <= '0;
            top_reg      <= '0;
            bot_reg      <= '0;
            span_vld_reg <= '0;
            hit_reg      <= 1'b0;
            status_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_DIM - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (req.operation == pgc_pkg::OP_CELL)
                        begin
                            crow_reg    <= crow_ext[AW-1:0];
                            ccol_reg    <= ccol_ext[AW-1:0];
                            cocc_reg    <= req.cell_occupied;
                            cell_ok_reg <= in_range;
                            state_reg   <= S_CELL_WR;
                        end
                        else
                        begin
                            if (!vfull)
                            begin
                                vcount_reg <= vcount_reg + CNTW'(1);
                                miny_reg   <= miny_n;
                                maxy_reg   <= maxy_n;
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                            if (req.last_vertex)
                            begin
                                vcount_reg <= '0;
                                ovf_reg    <= 1'b0;
                                if (ovf_now)
                                begin
                                    hit_reg    <= 1'b1;
                                    status_reg <= 1'b1;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    status_reg   <= 1'b0;
                                    n_reg        <= vcount_reg + CNTW'(1);
                                    top_reg      <= top_n;
                                    bot_reg      <= bot_n;
                                    span_vld_reg <= '0;
                                    hit_reg      <= early_hit;
                                    state_reg    <= early_hit ? S_DONE : S_LOAD0;
                                end
                            end
                        end
                    end
                end
                S_CELL_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_LOAD0:
                begin
                    state_reg <= S_FIRST;
                end
                S_FIRST:
                begin
                    first_reg <= vtx_q;
                    a_reg     <= vtx_q;
                    e_reg     <= '0;
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    // orient every edge downwards, the crossing x does not change
                    if (a_y <= b_y)
                    begin
                        tx_reg <= a_reg[31:16];
                        ty_reg <= a_y;
                        bx_reg <= b_vtx[31:16];
                        by_reg <= b_y;
                    end
                    else
                    begin
                        tx_reg <= b_vtx[31:16];
                        ty_reg <= b_y;
                        bx_reg <= a_reg[31:16];
                        by_reg <= a_y;
                    end
                    a_reg     <= b_vtx;
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    row_reg <= lt_c;
                    if (lt_c == lb_c)
                    begin
                        flat_reg  <= 1'b1;
                        lo_reg    <= mnx_c[15:FB];
                        hi_reg    <= mxx_c[15:FB];
                        state_reg <= S_SPAN_WR;
                    end
                    else
                    begin
                        flat_reg    <= 1'b0;
                        dx_reg      <= {bx_reg[15], bx_reg} - {tx_reg[15], tx_reg};
                        dy_reg      <= dy_c;
                        prod0_reg   <= tx_reg * dy_c;
                        py_reg      <= {ty_reg[15], ty_reg};
                        firstpt_reg <= 1'b1;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod1_reg <= dx_reg * $signed(py_reg - {ty_reg[15], ty_reg});
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    rem_reg   <= rem_init;
                    dsh_reg   <= dsh_init;
                    q_reg     <= '0;
                    k_reg     <= KW'(QW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - NW'(dsh_reg);
                    end
                    q_reg   <= {q_reg[QW-2:0], div_ge};
                    dsh_reg <= dsh_reg >> 1;
                    k_reg   <= k_reg - KW'(1);
                    if (k_reg == '0)
                    begin
                        state_reg <= S_PT;
                    end
                end
                S_PT:
                begin
                    prev_reg <= cell_c;
                    if (firstpt_reg)
                    begin
                        firstpt_reg <= 1'b0;
                        py_reg      <= 17'((int'(row_reg) + 1) << FB);
                        state_reg   <= S_MUL;
                    end
                    else
                    begin
                        lo_reg    <= (prev_reg < cell_c) ? prev_reg : cell_c;
                        hi_reg    <= (prev_reg < cell_c) ? cell_c : prev_reg;
                        state_reg <= S_SPAN_WR;
                    end
                end
                S_SPAN_WR:
                begin
                    span_vld_reg[row_idx] <= 1'b1;
                    if (!flat_reg && (row_reg != lb_c))
                    begin
                        row_reg <= row_reg + QW'(1);
                        if ((int'(row_reg) + 2) <= int'(lb_c))
                        begin
                            py_reg <= 17'((int'(row_reg) + 2) << FB);
                        end
                        else
                        begin
                            py_reg <= {by_reg[15], by_reg};
                        end
                        state_reg <= S_MUL;
                    end
                    else if (last_edge)
                    begin
                        row_reg   <= top_reg;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        e_reg     <= e_reg + VW'(1);
                        state_reg <= S_FETCH;
                    end
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_CHK;
                end
                S_WALK_CHK:
                begin
                    if (walk_hit)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (row_reg == bot_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        row_reg   <= row_reg + QW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
